[rtl/cbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbc_pkg: shared types and constants for the bytewise CRC checker
// Payload structs, configuration register map and width limits.
// ----------------------------------------------------------------------------
package cbc_pkg;

   localparam int unsigned CrcBits       = 16;
   localparam int unsigned PolyBits      = 17;
   localparam int unsigned WidthBits     = 5;
   localparam int unsigned CsrIndexBits  = 4;
   localparam int unsigned CsrDataBits   = 17;

   localparam logic [WidthBits-1:0] CrcWidthMin   = 5'd8;
   localparam logic [WidthBits-1:0] CrcWidthMax   = 5'd16;
   localparam logic [PolyBits-1:0]  PolyReset     = 17'h01021;
   localparam logic [WidthBits-1:0] CrcWidthReset = 5'd16;

   typedef enum logic [CsrIndexBits-1:0] {
      CSR_GENERATOR_POLY = 4'd0,
      CSR_CRC_WIDTH      = 4'd1
   } csr_index_type;

   typedef struct packed {
      logic [PolyBits-1:0]  generator_poly;
      logic [WidthBits-1:0] crc_size;
   } cfg_type;

   typedef struct packed {
      logic [7:0]         data_byte;
      logic               last_byte;
      logic [CrcBits-1:0] expected_crc;
   } req_payload_type;

   typedef struct packed {
      logic [CrcBits-1:0] crc_result;
      logic               crc_match;
   } rsp_payload_type;

endpackage
`default_nettype wire

[rtl/cbc_byte_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbc_byte_step: one-byte CRC update
// Folds one byte into the running CRC with eight MSB-first shift steps at the
// configured width. Pure combinational logic.
// ----------------------------------------------------------------------------
module cbc_byte_step (
   input  wire cbc_pkg::cfg_type     cfg,
   input  wire logic [15:0]          crc_in,
   input  wire logic [7:0]           data_byte,
   output logic [15:0]               crc_out
);
   import cbc_pkg::*;

   logic [WidthBits-1:0] width_eff;
   logic [3:0]           shift_amt;
   logic [15:0]          mask;
   logic [15:0]          poly_al;
   logic [15:0]          work;

   // Clamp width to the supported range
   always_comb begin
      if (cfg.crc_size < CrcWidthMin) begin
         width_eff = CrcWidthMin;
      end else if (cfg.crc_size > CrcWidthMax) begin
         width_eff = CrcWidthMax;
      end else begin
         width_eff = cfg.crc_size;
      end
   end

   // Work left-aligned in 16 bits so the top bit is always bit 15
   assign shift_amt = 4'(CrcWidthMax - width_eff);
   assign mask      = 16'hFFFF >> shift_amt;
   assign poly_al   = (cfg.generator_poly[15:0] & mask) << shift_amt;

   always_comb begin
      work = ((crc_in & mask) << shift_amt) ^ {data_byte, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (work[15]) begin
            work = {work[14:0], 1'b0} ^ poly_al;
         end else begin
            work = {work[14:0], 1'b0};
         end
      end
   end

   assign crc_out = work >> shift_amt;

endmodule
`default_nettype wire

[rtl/crc_check_bytewise_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc_check_bytewise_core: bytewise CRC checker, configurable width and poly
// Keeps a running MSB-first CRC (zero init, no final XOR) over message bytes
// and, on the last byte, reports the CRC and whether it matches the expected
// value carried with that byte.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  cbc_pkg::req_payload_type
//   rsp_      out         rsp_valid/rsp_stall  cbc_pkg::rsp_payload_type
//   csr_      in          csr_valid/csr_ready  csr_index, csr_wdata
//
// One byte per cycle while req_stall is low: the eight shift steps are unrolled
// XOR logic between the running CRC register and the result register; a last
// byte shows its result in the cycle after its transfer.
// Reset (synchronous) clears the running CRC and the result valid, and loads
// polynomial 0x1021 with width 16.
// req_stall rises only while a result is held and rsp_stall is high.
// csr_ready is always high; write registers only while the block is idle.
// ----------------------------------------------------------------------------
module crc_check_bytewise_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire cbc_pkg::req_payload_type    req_payload,
   // response channel
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output cbc_pkg::rsp_payload_type         rsp_payload,
   // configuration write channel
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [cbc_pkg::CsrIndexBits-1:0] csr_index,
   input  wire logic [cbc_pkg::CsrDataBits-1:0]  csr_wdata
);
   import cbc_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic [15:0]      crc_ff, crc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_payload_ff, rsp_payload_in;
   logic [15:0]      crc_next;
   logic             req_xfer;
   logic             last_xfer;
   logic             csr_xfer;

   // Hold requests only when the result register is full and not draining
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_xfer  = req_valid & ~req_stall;
   assign last_xfer = req_xfer & req_payload.last_byte;

   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid & csr_ready;

   // Configuration registers; drop writes beyond the register map
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_xfer) begin
         unique case (csr_index_type'(csr_index))
            CSR_GENERATOR_POLY: cfg_in.generator_poly = csr_wdata[PolyBits-1:0];
            CSR_CRC_WIDTH:      cfg_in.crc_size       = csr_wdata[WidthBits-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   cbc_byte_step u_step (
      .cfg       (cfg_ff),
      .crc_in    (crc_ff),
      .data_byte (req_payload.data_byte),
      .crc_out   (crc_next)
   );

   // Advance the running CRC on every transfer; clear it after the last byte
   always_comb begin
      crc_in = crc_ff;
      if (req_xfer) begin
         crc_in = req_payload.last_byte ? 16'h0000 : crc_next;
      end
   end

   // Result register: load on a last-byte transfer, hold while stalled
   assign rsp_valid_in = last_xfer | (rsp_valid_ff & rsp_stall);

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      if (last_xfer) begin
         rsp_payload_in.crc_result = crc_next;
         rsp_payload_in.crc_match  = (crc_next == req_payload.expected_crc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.generator_poly <= PolyReset;
         cfg_ff.crc_size       <= CrcWidthReset;
         crc_ff                <= 16'h0000;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A last-byte transfer shows a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      last_xfer |=> rsp_valid)
      else $error("last-byte transfer did not produce a result");

   // The running CRC starts from zero for the next message
   assert property (@(posedge clock) disable iff (reset)
      last_xfer |=> (crc_ff == 16'h0000))
      else $error("running CRC not cleared after last byte");

   // A held result is never overwritten by a new last byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_payload) && rsp_valid))
      else $error("stalled result changed or was lost");

endmodule
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: regression bench for crc_check_bytewise_core
// Streams CRC messages under several polynomial and width settings and with
// random gaps and stalls on both channels. A bytewise CRC predictor in the
// bench computes the expected result of every last byte. Each result transfer
// is checked field by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb;
   import cbc_pkg::*;

   localparam int unsigned ItemsPerPhase = 250;
   localparam int unsigned SettleCycles  = 4;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // ports of the block, inputs all known from time zero
   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   req_payload_type         req_payload = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   rsp_payload_type         rsp_payload;
   logic                    csr_valid   = 1'b0;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index   = '0;
   logic [CsrDataBits-1:0]  csr_wdata   = '0;

   // bench copy of the configuration, updated on each CSR write transfer
   logic [PolyBits-1:0]  cfg_poly  = PolyReset;
   logic [WidthBits-1:0] cfg_width = CrcWidthReset;

   // running CRC on the predictor side (advanced on each request transfer)
   // and on the stimulus side (advanced as bytes are queued)
   logic [PolyBits-1:0] predicted_crc = '0;
   logic [PolyBits-1:0] stimulus_crc  = '0;

   req_payload_type byte_q[$];     // bytes waiting to be sent
   rsp_payload_type crc_result_q[$]; // CRC results still to arrive

   logic        req_xfer    = 1'b0;  // a request transfer happened at the last edge
   int unsigned gap_pct     = 0;
   int unsigned stall_pct   = 0;
   int unsigned error_count = 0;
   int unsigned queued      = 0;

   crc_check_bytewise_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #6 clock = ~clock;

   // Width outside 8..16 behaves as the nearest limit.
   function automatic int unsigned clamp_width(input logic [WidthBits-1:0] width);
      if (width < CrcWidthMin) return 32'(CrcWidthMin);
      if (width > CrcWidthMax) return 32'(CrcWidthMax);
      return 32'(width);
   endfunction

   // Fold one byte into the CRC, MSB first. The stored CRC is masked to the
   // width in force now, which covers a width change in mid-message.
   function automatic logic [PolyBits-1:0] crc_advance(input logic [PolyBits-1:0] crc_in,
                                                       input logic [7:0] data,
                                                       input logic [PolyBits-1:0] poly,
                                                       input logic [WidthBits-1:0] width);
      int unsigned         w;
      logic [PolyBits-1:0] mask;
      logic [PolyBits-1:0] crc;
      logic                top;
      int                  i;
      w    = clamp_width(width);
      mask = (PolyBits'(1) << w) - PolyBits'(1);
      crc  = ((crc_in & mask) ^ (PolyBits'(data) << (w - 8))) & mask;
      for (i = 0; i < 8; i++) begin
         top = crc[w-1];
         crc = ((crc << 1) ^ (top ? poly : PolyBits'(0))) & mask;
      end
      return crc;
   endfunction

   task automatic flag_error(input string what, input int unsigned want_v,
                             input int unsigned got_v);
      if (error_count < 10) begin
         $display("%0t ns: %s: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
      end
      error_count++;
   endtask

   // Queue one byte and keep the stimulus-side CRC in step, so that a good
   // expected value can be built for the last byte of a message.
   task automatic queue_byte(input logic [7:0] data, input logic last,
                             input logic [CrcBits-1:0] exp_crc);
      req_payload_type item;
      item.data_byte    = data;
      item.last_byte    = last;
      item.expected_crc = exp_crc;
      byte_q.push_back(item);
      stimulus_crc = last ? '0 : crc_advance(stimulus_crc, data, cfg_poly, cfg_width);
      queued++;
   endtask

   // One well-formed message of random bytes. The expected CRC on the last
   // byte is right half the time; otherwise one bit is flipped, it is random, or
   // it carries set bits above the CRC width.
   task automatic send_message(input int unsigned len);
      logic [PolyBits-1:0] final_crc;
      logic [CrcBits-1:0]  good;
      logic [7:0]          data;
      int unsigned         roll;
      repeat (len - 1) queue_byte(8'($urandom), 1'b0, 16'($urandom));
      data      = 8'($urandom);
      final_crc = crc_advance(stimulus_crc, data, cfg_poly, cfg_width);
      good      = final_crc[CrcBits-1:0];
      roll      = $urandom_range(99);
      if (roll < 50) begin
         queue_byte(data, 1'b1, good);
      end else if (roll < 70) begin
         queue_byte(data, 1'b1, good ^ (16'd1 << $urandom_range(15)));
      end else if (roll < 85) begin
         queue_byte(data, 1'b1, 16'($urandom));
      end else begin
         queue_byte(data, 1'b1, good | (16'hFFFF << clamp_width(cfg_width)));
      end
   endtask

   // Write one register; track the write in the bench copy once it transfers.
   // Indexes beyond the register map are ignored by the block.
   task automatic write_csr(input logic [CsrIndexBits-1:0] index,
                            input logic [CsrDataBits-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == CSR_GENERATOR_POLY) begin
         cfg_poly = value[PolyBits-1:0];
      end else if (index == CSR_CRC_WIDTH) begin
         cfg_width = value[WidthBits-1:0];
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [PolyBits-1:0] poly, input logic [WidthBits-1:0] width);
      write_csr(CSR_GENERATOR_POLY, poly);
      write_csr(CSR_CRC_WIDTH, CsrDataBits'(width));
      write_csr(CsrIndexBits'($urandom_range(15, 2)), CsrDataBits'($urandom));
   endtask

   // Hold until every queued byte has transferred and every result has come
   // back, then let the block settle before anything else is written.
   task automatic drain;
      while (byte_q.size() != 0 || crc_result_q.size() != 0 || req_valid) begin
         @(posedge clock);
      end
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_idling(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            gap_pct = 0;  stall_pct = 0;
         end
         IDLE_SENDER: begin
            gap_pct = 57; stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            gap_pct = 0;  stall_pct = 57;
         end
         default: begin
            gap_pct = 7;  stall_pct = 7;
         end
      endcase
   endtask

   // Request driver: change inputs on the falling edge. Hold a stalled
   // transfer as it is; otherwise present the next byte unless idling.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_xfer) begin
         if (byte_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
            req_valid   <= 1'b1;
            req_payload <= byte_q[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver backpressure, drawn fresh each cycle.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Request side: on each transfer, drop the byte from the send queue and
   // advance the predicted CRC. A last byte yields one expected result and
   // clears the running CRC.
   always @(posedge clock) begin
      logic [PolyBits-1:0] next_crc;
      rsp_payload_type     want;
      req_xfer <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         void'(byte_q.pop_front());
         next_crc = crc_advance(predicted_crc, req_payload.data_byte, cfg_poly, cfg_width);
         if (req_payload.last_byte) begin
            want.crc_result = next_crc[CrcBits-1:0];
            want.crc_match  = (next_crc[CrcBits-1:0] == req_payload.expected_crc);
            crc_result_q.push_back(want);
            predicted_crc = '0;
         end else begin
            predicted_crc = next_crc;
         end
      end
   end

   // Result monitor: compare each result transfer with the oldest expectation.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (crc_result_q.size() == 0) begin
            flag_error("unexpected result, crc_result", 0, 32'(rsp_payload.crc_result));
         end else begin
            want = crc_result_q.pop_front();
            if (rsp_payload.crc_result !== want.crc_result) begin
               flag_error("crc_result", 32'(want.crc_result), 32'(rsp_payload.crc_result));
            end
            if (rsp_payload.crc_match !== want.crc_match) begin
               flag_error("crc_match", 32'(want.crc_match), 32'(rsp_payload.crc_match));
            end
         end
      end
   end

   initial begin
      logic [PolyBits-1:0]  final_crc;
      logic [PolyBits-1:0]  phase_poly[6];
      logic [WidthBits-1:0] phase_width[6];
      int unsigned          phase;
      int unsigned          goal;
      int unsigned          len;
      phase_poly  = '{17'h01021, 17'h08005, 17'h0180D, 17'h00007, 17'h1FFFF, 17'h00000};
      phase_width = '{5'd16, 5'd16, 5'd12, 5'd8, 5'd17, 5'd0};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings, extreme bytes and expected values, and the
      // standard nine-byte check string.
      set_idling(IDLE_NONE);
      queue_byte(8'h00, 1'b1, 16'h0000);
      queue_byte(8'hFF, 1'b1, 16'hFFFF);
      for (int i = 0; i < 8; i++) queue_byte(8'h31 + 8'(i), 1'b0, 16'h0000);
      queue_byte(8'h39, 1'b1, 16'h31C3);
      drain();

      // Ignore a write beyond the map; then a 12-bit CRC, with an expected
      // value that carries bits above the width, and the clean one.
      write_csr(CsrIndexBits'(15), 17'h1FFFF);
      configure(17'h0180D, 5'd12);
      final_crc = crc_advance('0, 8'hA5, cfg_poly, cfg_width);
      queue_byte(8'hA5, 1'b1, final_crc[CrcBits-1:0] | 16'hF000);
      queue_byte(8'hA5, 1'b1, final_crc[CrcBits-1:0]);
      drain();

      // Change the width in mid-message.
      queue_byte(8'h5A, 1'b0, 16'h0000);
      drain();
      write_csr(CSR_CRC_WIDTH, 17'd16);
      final_crc = crc_advance(stimulus_crc, 8'hC3, cfg_poly, cfg_width);
      queue_byte(8'hC3, 1'b1, final_crc[CrcBits-1:0]);
      drain();

      // Widths below and above range, all-ones and zero polynomials.
      configure(17'h00007, 5'd0);
      final_crc = crc_advance('0, 8'hFF, cfg_poly, cfg_width);
      queue_byte(8'hFF, 1'b1, final_crc[CrcBits-1:0]);
      drain();
      configure(17'h1FFFF, 5'd31);
      queue_byte(8'h80, 1'b1, 16'h0000);
      drain();
      configure(17'h00000, 5'd8);
      queue_byte(8'h81, 1'b1, 16'h0081);
      drain();

      // Random messages, one setting and one idling mode per phase.
      for (phase = 0; phase < 8; phase++) begin
         if (phase < 6) begin
            configure(phase_poly[phase], phase_width[phase]);
         end else begin
            configure(PolyBits'($urandom_range(131071)), WidthBits'($urandom_range(31)));
         end
         set_idling(idle_mode_type'(phase % 4));
         goal = queued + ItemsPerPhase;
         while (queued < goal) begin
            // halfway through odd phases, pause until every result is back
            if (phase % 2 == 1 && queued >= goal - ItemsPerPhase / 2
                && queued < goal - ItemsPerPhase / 2 + 4) begin
               drain();
            end
            if ($urandom_range(99) < 10) begin
               queue_byte(8'($urandom), 1'($urandom), 16'($urandom));
            end else begin
               len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
               send_message(len);
            end
            @(negedge clock);
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Stop a hung run well beyond the slowest correct one.
   initial begin
      #(5_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
